>>> hw/rtl/dctg_pkg.sv
// Package of the duty-cycle tone generator: constants, operation codes and control structs.
package dctg_pkg;

  // Default prescaled tick rate of the tone counter.
  localparam int TICKS_PER_SECOND_DEF = 125000;

  // Widths fixed by the item fields.
  localparam int OP_W     = 2;
  localparam int FREQ_W   = 13;
  localparam int DUTY_W   = 6;
  localparam int TIME_W   = 16;
  // Divisor of the high-time division is 100 times the frequency.
  localparam int DIVISOR_W = 20;
  localparam int PERCENT   = 100;

  localparam logic [DUTY_W-1:0] DUTY_RESET = 6'd50;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  typedef struct packed {
    logic apply;   // apply an item that needs no division and register its result
    logic load_p;  // load the divider with the period operands
    logic load_h;  // keep the period and load the high-time operands
    logic step;    // one quotient bit
    logic finish;  // store the new times and register the result
  } dctg_cmd_t;

  typedef struct packed {
    logic note_start;  // input item is a start with a non-zero frequency
    logic div_last;    // the current divider step is the last one
  } dctg_status_t;

endpackage

>>> hw/rtl/dctg_in_if.sv
// Input channel of the tone generator: operation and frequency with valid/ready.
interface dctg_in_if;
  import dctg_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [FREQ_W-1:0] frequency_hz;

  modport source (output valid, output operation, output frequency_hz, input ready);
  modport sink (input valid, input operation, input frequency_hz, output ready);
endinterface

>>> hw/rtl/dctg_out_if.sv
// Output channel of the tone generator: speaker level and tone status with valid/ready.
interface dctg_out_if;
  logic valid;
  logic ready;
  logic speaker_level;
  logic tone_active;

  modport source (output valid, output speaker_level, output tone_active, input ready);
  modport sink (input valid, input speaker_level, input tone_active, output ready);
endinterface

>>> hw/rtl/dctg_ctrl.sv
// Controller of the tone generator: sequences the two divisions and the output handshake.
module dctg_ctrl
  import dctg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  dctg_status_t status_i,
  output dctg_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV_P = 5'b00010,
    S_LOAD_H = 5'b00100,
    S_DIV_H = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (status_i.note_start) begin
            cmd_o.load_p = 1'b1;
            state_d      = S_DIV_P;
          end else begin
            cmd_o.apply = 1'b1;
          end
        end
      end
      S_DIV_P: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_LOAD_H;
        end
      end
      S_LOAD_H: begin
        cmd_o.load_h = 1'b1;
        state_d      = S_DIV_H;
      end
      S_DIV_H: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // The output register was free when the start item was taken.
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.apply || cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hw/rtl/dctg_datapath.sv
// Datapath of the tone generator: tone state, duty register and a bit-serial divider.
module dctg_datapath
  import dctg_pkg::*;
#(
  parameter int TicksPerSecond = TICKS_PER_SECOND_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [DUTY_W-1:0] cfg_wdata_i,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [FREQ_W-1:0] frequency_hz_i,
  input  dctg_cmd_t         cmd_i,
  output dctg_status_t      status_o,
  output logic              speaker_level_o,
  output logic              tone_active_o
);

  // The largest dividend is the tick rate times the largest duty value.
  localparam int DuMax = TicksPerSecond * ((1 << DUTY_W) - 1);
  localparam int DW    = $clog2(DuMax + 1);
  localparam int CntW  = $clog2(DW);
  localparam int SW    = (DW > TIME_W + 1) ? DW : TIME_W + 1;

  logic [DUTY_W-1:0]    duty_q;
  logic                 running_q, running_d;
  logic                 level_q, level_d;
  logic [TIME_W-1:0]    remaining_q, remaining_d;
  logic [TIME_W-1:0]    high_q, high_d;
  logic [TIME_W-1:0]    low_q, low_d;
  logic [FREQ_W-1:0]    freq_q;
  logic [DW-1:0]        period_q;
  logic [DW-1:0]        quo_q, quo_d;
  logic [DIVISOR_W:0]   rem_q, rem_d;
  logic [DIVISOR_W-1:0] divisor_q, divisor_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 out_level_q, out_active_q;

  logic [DIVISOR_W:0]   rem_sh;
  logic [TIME_W-1:0]    rem_dec;
  logic [DW-1:0]        low_raw;

  function automatic logic [TIME_W-1:0] sat16(input logic [DW-1:0] v);
    logic [SW-1:0] ext;
    ext = SW'(v);
    return (ext > SW'({TIME_W{1'b1}})) ? {TIME_W{1'b1}} : ext[TIME_W-1:0];
  endfunction

  assign status_o.note_start = (operation_i == OP_START) && (frequency_hz_i != '0);
  assign status_o.div_last   = (cnt_q == CntW'(DW - 1));

  // Restoring division, one quotient bit per step; quo_q holds the dividend
  // and fills with quotient bits from the right.
  assign rem_sh  = {rem_q[DIVISOR_W-1:0], quo_q[DW-1]};
  assign rem_dec = remaining_q - TIME_W'(1);
  assign low_raw = (period_q >= quo_q) ? (period_q - quo_q) : '0;

  always_comb begin
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    cnt_d     = cnt_q;
    if (cmd_i.load_p) begin
      quo_d     = DW'(TicksPerSecond);
      divisor_d = DIVISOR_W'(frequency_hz_i);
      rem_d     = '0;
      cnt_d     = '0;
    end else if (cmd_i.load_h) begin
      quo_d     = DW'(TicksPerSecond) * DW'(duty_q);
      divisor_d = DIVISOR_W'(freq_q) * DIVISOR_W'(PERCENT);
      rem_d     = '0;
      cnt_d     = '0;
    end else if (cmd_i.step) begin
      cnt_d = cnt_q + CntW'(1);
      if (rem_sh >= {1'b0, divisor_q}) begin
        rem_d = rem_sh - {1'b0, divisor_q};
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    running_d   = running_q;
    level_d     = level_q;
    remaining_d = remaining_q;
    high_d      = high_q;
    low_d       = low_q;
    if (cmd_i.apply) begin
      unique case (operation_i)
        OP_TICK: begin
          if (running_q) begin
            remaining_d = rem_dec;
            if (rem_dec == '0) begin
              level_d     = !level_q;
              remaining_d = level_q ? low_q : high_q;
            end
          end
        end
        OP_STOP: begin
          running_d = 1'b0;
        end
        default: begin
          // A rest and the unused code leave the state as it is.
        end
      endcase
    end else if (cmd_i.finish) begin
      high_d      = sat16(quo_q);
      low_d       = sat16(low_raw);
      remaining_d = sat16(quo_q);
      running_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q      <= DUTY_RESET;
      running_q   <= 1'b0;
      level_q     <= 1'b0;
      remaining_q <= '0;
      high_q      <= '0;
      low_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        duty_q <= cfg_wdata_i;
      end
      running_q   <= running_d;
      level_q     <= level_d;
      remaining_q <= remaining_d;
      high_q      <= high_d;
      low_q       <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    cnt_q     <= cnt_d;
    if (cmd_i.load_p) begin
      freq_q <= frequency_hz_i;
    end
    if (cmd_i.load_h) begin
      period_q <= quo_q;
    end
    if (cmd_i.apply || cmd_i.finish) begin
      out_level_q  <= level_d;
      out_active_q <= running_d;
    end
  end

  assign speaker_level_o = out_level_q;
  assign tone_active_o   = out_active_q;

endmodule

>>> hw/rtl/duty_cycle_tone_generator.sv
// Top level of the duty-cycle tone generator: controller, datapath and channel wiring.
//
//   channel  direction  handshake          payload
//   in_i     sink       valid/ready        operation[1:0], frequency_hz[12:0]
//   out_o    source     valid/ready        speaker_level, tone_active
//   cfg      write      cfg_we_i           cfg_wdata_i[5:0] = duty_percent
//
// A tick, stop, rest or unused-code item is applied when it is taken and its
// result is registered at once. A start item with a non-zero frequency runs
// the bit-serial divider, whose dividend width is DW, first for the period and
// then for the high time, before the new times and the result are registered.
// Reset is asynchronous and active low and leaves the tone stopped at level 0.
// A new item is taken while idle and the output register is empty or being read.
module duty_cycle_tone_generator
  import dctg_pkg::*;
#(
  parameter int TicksPerSecond = TICKS_PER_SECOND_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [DUTY_W-1:0] cfg_wdata_i,
  dctg_in_if.sink           in_i,
  dctg_out_if.source        out_o
);

  dctg_cmd_t    cmd;
  dctg_status_t status;

  dctg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dctg_datapath #(
    .TicksPerSecond (TicksPerSecond)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .operation_i     (in_i.operation),
    .frequency_hz_i  (in_i.frequency_hz),
    .cmd_i           (cmd),
    .status_o        (status),
    .speaker_level_o (out_o.speaker_level),
    .tone_active_o   (out_o.tone_active)
  );

endmodule
